// ===== rtl/aigc_pkg.sv =====
// Shared types and coefficient tables for the approximate inverse Gaussian CDF.
package aigc_pkg;

    localparam int IDX_W   = 4;   // interval index width (16 stored segments)
    localparam int STORED  = 16;
    localparam int FRAC_W  = 32;  // folded fraction aligned to Q0.32
    localparam int C0_W    = 20;  // signed Q15.16 offsets fit in 20 bits
    localparam int C1_W    = 31;  // unsigned Q15.16 slopes fit in 31 bits
    localparam int PROD_W  = FRAC_W + C1_W;
    localparam int SUM_W   = 64;
    localparam int RND_SH  = 21;  // Q15.48 -> Q4.27
    localparam int RND_W   = SUM_W - RND_SH;
    localparam int OUT_W   = 31;

    localparam logic signed [OUT_W-1:0] OUT_LIMIT = 31'sd671088640;  // 5.0 in Q4.27

    typedef logic [IDX_W-1:0] t_idx;

    // folded sample with its segment coefficients
    typedef struct packed {
        logic                   upper;
        logic [FRAC_W-1:0]      frac;
        logic signed [C0_W-1:0] c0;
        logic [C1_W-1:0]        c1;
    } t_seg;

    localparam logic signed [C0_W-1:0] C0_TAB [STORED] = '{
        20'sd0,       -20'sd86970,  -20'sd104996, -20'sd124202,
        -20'sd142232, -20'sd158955, -20'sd174519, -20'sd189095,
        -20'sd202829, -20'sd215838, -20'sd228219, -20'sd240049,
        -20'sd251393, -20'sd262303, -20'sd272823, -20'sd299110
    };

    localparam logic [C1_W-1:0] C1_TAB [STORED] = '{
        31'd0,         31'd175181,    31'd247020,     31'd397946,
        31'd680898,    31'd1205771,   31'd2183103,    31'd4014170,
        31'd7465469,   31'd14005597,  31'd26456583,   31'd50255452,
        31'd95901975,  31'd183715380, 31'd353091315,  31'd1417716448
    };

endpackage

// ===== rtl/aigc_seg.sv =====
// Fold onto the lower half, find the dyadic segment, align and look up coefficients.
module aigc_seg #(
    parameter int UNIFORM_BITS  = 32,
    parameter int TABLE_ENTRIES = 16
) (
    input  logic [UNIFORM_BITS-1:0] i_uniform,
    output aigc_pkg::t_seg          o_seg
);
    import aigc_pkg::*;

    // deepest segment reachable: last table entry or last stored entry, whichever is lower
    localparam int LZ_MAX = (TABLE_ENTRIES - 1 < STORED - 1) ? TABLE_ENTRIES - 1 : STORED - 1;

    logic                    w_upper;
    logic [UNIFORM_BITS-1:0] w_neg;
    logic [UNIFORM_BITS-1:0] w_f;
    logic [FRAC_W-1:0]       w_frac;
    t_idx                    w_idx;

    assign w_upper = i_uniform[UNIFORM_BITS-1];
    assign w_neg   = '0 - i_uniform;

    always_comb begin
        w_f = w_upper ? w_neg : i_uniform;
        // zero code behaves as the smallest nonzero code
        if (w_f == '0) begin
            w_f = {{(UNIFORM_BITS-1){1'b0}}, 1'b1};
        end
    end

    // leading zeros, only counted as far as the clamp
    always_comb begin
        w_idx = IDX_W'(LZ_MAX);
        for (int i = LZ_MAX - 1; i >= 0; i--) begin
            if (w_f[UNIFORM_BITS-1-i]) begin
                w_idx = IDX_W'(i);
            end
        end
    end

    generate
        if (UNIFORM_BITS >= FRAC_W) begin : g_trunc
            assign w_frac = w_f[UNIFORM_BITS-1 -: FRAC_W];
        end else begin : g_pad
            assign w_frac = {w_f, {(FRAC_W-UNIFORM_BITS){1'b0}}};
        end
    endgenerate

    always_comb begin
        o_seg.upper = w_upper;
        o_seg.frac  = w_frac;
        o_seg.c0    = C0_TAB[w_idx];
        o_seg.c1    = C1_TAB[w_idx];
    end

endmodule

// ===== rtl/approx_inverse_gaussian_cdf.sv =====
// Top level: pipelined piecewise-linear inverse normal CDF on dyadic segments.
// Throughput: one transaction per clock; busy is tied low, start is always taken.
// Pipeline: input reg, segment/coef reg, product reg (32x31 multiply), rounded sum reg,
// then saturate/negate into the result reg. The receiver cannot stall; none is needed.
// Reset (i_rst_n low, synchronous) clears the valid pipe; payload regs are not reset.
module approx_inverse_gaussian_cdf #(
    parameter int TABLE_ENTRIES = 16,
    parameter int UNIFORM_BITS  = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [UNIFORM_BITS-1:0]               i_uniform,
    output logic                                  o_valid,
    output logic signed [aigc_pkg::OUT_W-1:0]     o_gaussian
);
    import aigc_pkg::*;

    // stage 0: captured input
    logic [UNIFORM_BITS-1:0] r_u;
    // stage 1: fold + segment lookup
    t_seg                    w_seg;
    t_seg                    r_seg;
    // stage 2: slope product
    logic [PROD_W-1:0]       r_prod;
    logic signed [C0_W-1:0]  r_c0;
    logic                    r_up_p;
    // stage 3: offset add + round half up to Q4.27
    logic signed [SUM_W-1:0] w_sum;
    logic signed [RND_W-1:0] r_rnd;
    logic                    r_up_r;
    // stage 4: saturate, negate for upper half
    logic signed [OUT_W-1:0] w_sat;
    logic signed [OUT_W-1:0] n_gaussian;

    logic [3:0]              r_vld;

    // the datapath never holds off a transaction
    assign busy = 1'b0;

    aigc_seg #(
        .UNIFORM_BITS  (UNIFORM_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_seg (
        .i_uniform (r_u),
        .o_seg     (w_seg)
    );

    // c0 is Q15.16, moved to Q15.48; product is already Q15.48.
    // Sum stays far inside 64 bits, so the floor shift is a plain part-select.
    assign w_sum = $signed({{(SUM_W-C0_W-FRAC_W){r_c0[C0_W-1]}}, r_c0, {FRAC_W{1'b0}}})
                 + $signed({{(SUM_W-PROD_W){1'b0}}, r_prod})
                 + $signed(SUM_W'(64'd1 << (RND_SH - 1)));

    always_comb begin
        if (r_rnd > RND_W'(OUT_LIMIT)) begin
            w_sat = OUT_LIMIT;
        end else if (r_rnd < -RND_W'(OUT_LIMIT)) begin
            w_sat = -OUT_LIMIT;
        end else begin
            w_sat = r_rnd[OUT_W-1:0];
        end
        n_gaussian = r_up_r ? -w_sat : w_sat;
    end

    // payload pipeline, no reset
    always_ff @(posedge i_clk) begin
        r_u        <= i_uniform;
        r_seg      <= w_seg;
        r_prod     <= PROD_W'(r_seg.frac) * PROD_W'(r_seg.c1);
        r_c0       <= r_seg.c0;
        r_up_p     <= r_seg.upper;
        r_rnd      <= w_sum[SUM_W-1:RND_SH];
        r_up_r     <= r_up_p;
        o_gaussian <= n_gaussian;
    end

    // valid tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[2:0], start & ~busy};
            o_valid <= r_vld[3];
        end
    end

endmodule

// ===== rtl/aigc_chk.sv =====
// Port-level checker for the inverse Gaussian CDF block, bound to the top level.
module aigc_chk #(
    parameter int UNIFORM_BITS = 32
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic [UNIFORM_BITS-1:0]               i_uniform,
    input logic                                  o_valid,
    input logic signed [aigc_pkg::OUT_W-1:0]     o_gaussian
);
    import aigc_pkg::*;

    localparam int LAT = 5;  // accepting edge to result-accepting edge

    localparam logic [UNIFORM_BITS-1:0] HALF = {1'b1, {(UNIFORM_BITS-1){1'b0}}};

    // a result needs a matching transaction taken earlier
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result strobe without matching transaction");

    // every taken transaction yields a result
    a_strobe_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("pipeline control mismatch");

    // results stay inside the +/-5.0 clamp
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_gaussian <= OUT_LIMIT && o_gaussian >= -OUT_LIMIT))
        else $error("result outside saturation range");

    // exactly one half maps to zero
    a_half_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(start && !busy && i_uniform == HALF, LAT)) |-> (o_gaussian == '0))
        else $error("one half did not map to zero");

    // command port never stalls
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy asserted");

endmodule

bind approx_inverse_gaussian_cdf aigc_chk #(.UNIFORM_BITS(UNIFORM_BITS)) u_aigc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_uniform  (i_uniform),
    .o_valid    (o_valid),
    .o_gaussian (o_gaussian)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the approximate inverse Gaussian CDF block.
`timescale 1ns / 100ps

module testbench;

    import aigc_pkg::*;

    localparam int N_RANDOM   = 550;
    localparam int DRAIN_TAIL = 8;   // pipeline is 5 deep, leave some slack

    // Segment table: Q15.16 offset and slope per dyadic interval
    int seg_offset [16] = '{
        0,       -86970,  -104996, -124202, -142232, -158955, -174519, -189095,
        -202829, -215838, -228219, -240049, -251393, -262303, -272823, -299110
    };
    int seg_slope [16] = '{
        0,        175181,   247020,    397946,    680898,    1205771,
        2183103,  4014170,  7465469,   14005597,  26456583,  50255452,
        95901975, 183715380, 353091315, 1417716448
    };

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    start      = 1'b0;
    logic [31:0]             i_uniform  = '0;
    logic                    busy;
    logic                    o_valid;
    logic signed [OUT_W-1:0] o_gaussian;

    logic [31:0]             uniform_backlog [$];  // samples waiting to be sent
    logic signed [OUT_W-1:0] gaussian_due [$];     // predicted results in order
    int                      mismatches = 0;
    int                      sent       = 0;
    int                      hold_off   = 0;
    int                      gap_style  = 0;
    bit                      stim_done  = 1'b0;

    approx_inverse_gaussian_cdf dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_uniform  (i_uniform),
        .o_valid    (o_valid),
        .o_gaussian (o_gaussian)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Predicted output for one uniform sample.
    // Fold to the lower half, pick the interval from the leading zeros (capped at
    // the last segment), evaluate offset + frac * slope in Q15.48, round half up
    // to Q4.27, clip to +/-5.0 and flip the sign for the upper half.
    function automatic logic signed [OUT_W-1:0] inv_cdf(logic [31:0] u);
        logic        upper;
        logic [31:0] frac;
        int          seg;
        longint      acc;
        longint      z;
        upper = u[31];
        frac  = upper ? (~u + 32'd1) : u;
        if (frac == 32'd0)
            frac = 32'd1;       // zero code behaves like the smallest code
        seg = 0;
        while (seg < 15 && !frac[31 - seg])
            seg++;
        acc = longint'(seg_offset[seg]) * 64'sd4294967296
            + longint'({32'd0, frac}) * longint'(seg_slope[seg]);
        z = (acc + 64'sd1048576) >>> 21;
        if (z > 64'sd671088640)
            z = 64'sd671088640;
        if (z < -64'sd671088640)
            z = -64'sd671088640;
        if (upper)
            z = -z;
        return z[OUT_W-1:0];
    endfunction

    // Idle cycles before the next transaction; the style rotates so there are
    // back-to-back bursts, fully random gaps and mostly back-to-back with occasional gaps.
    function automatic int draw_gap(int style);
        case (style)
            0:       return 0;
            1:       return $urandom_range(0, 16);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    // Reset, then stimulus: directed corner cases first, then random samples
    initial begin
        logic [31:0] v;
        int          k;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, exact half, zero code, fold edges, deep tail clamp boundary
        uniform_backlog.push_back(32'h0000_0000);
        uniform_backlog.push_back(32'h0000_0001);
        uniform_backlog.push_back(32'h0000_0002);
        uniform_backlog.push_back(32'hFFFF_FFFF);
        uniform_backlog.push_back(32'hFFFF_FFFE);
        uniform_backlog.push_back(32'h8000_0000);
        uniform_backlog.push_back(32'h7FFF_FFFF);
        uniform_backlog.push_back(32'h8000_0001);
        uniform_backlog.push_back(32'h4000_0000);
        uniform_backlog.push_back(32'h3FFF_FFFF);
        uniform_backlog.push_back(32'hC000_0000);
        uniform_backlog.push_back(32'hBFFF_FFFF);
        uniform_backlog.push_back(32'h0002_0000);
        uniform_backlog.push_back(32'h0001_FFFF);
        uniform_backlog.push_back(32'h0001_0000);
        uniform_backlog.push_back(32'h0000_FFFF);
        uniform_backlog.push_back(32'hFFFF_0000);
        uniform_backlog.push_back(32'hFFFF_0001);
        uniform_backlog.push_back(32'h5555_5555);
        uniform_backlog.push_back(32'hAAAA_AAAA);

        // random: a third uniform over the full code range, the rest spread
        // evenly over the dyadic intervals on both sides of one half
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                v = $urandom;
            end else begin
                k = $urandom_range(0, 31);
                v = ($urandom >> k) | (32'h8000_0000 >> k);
                if (k > 0 && $urandom_range(0, 1))
                    v = ~v + 32'd1;
            end
            uniform_backlog.push_back(v);
        end
        stim_done = 1'b1;
    end

    // Driver: a transaction is taken at the edge where start is high and busy low
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                gaussian_due.push_back(inv_cdf(i_uniform));
                sent++;
                if (sent % 64 == 0)
                    gap_style = (gap_style + 1) % 3;
                hold_off = draw_gap(gap_style);
            end
            if (start && busy) begin
                // hold the current transaction until taken
            end else if (hold_off > 0) begin
                hold_off--;
                start <= 1'b0;
            end else if (uniform_backlog.size() > 0) begin
                start     <= 1'b1;
                i_uniform <= uniform_backlog.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: each strobed result is checked against the oldest prediction
    always @(posedge i_clk) begin
        logic signed [OUT_W-1:0] want;
        if (i_rst_n && o_valid) begin
            if (gaussian_due.size() == 0) begin
                $error("unexpected result: gaussian %0d with nothing pending", o_gaussian);
                mismatches++;
            end else begin
                want = gaussian_due.pop_front();
                if (o_gaussian !== want) begin
                    $error("gaussian mismatch: expected %0d, actual %0d", want, o_gaussian);
                    mismatches++;
                end
            end
        end
    end

    // End of run: all sent, all results back, then let the pipe drain
    initial begin
        @(posedge i_clk);
        while (!stim_done || uniform_backlog.size() > 0 || start || gaussian_due.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatches == 0 && gaussian_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (~600 transactions)
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
